>>> design/dnle_pkg.sv
// shared constants, controller states and control structs of the dns name label encoder
package dnle_pkg;

  localparam int MaxLabel = 63;
  localparam int LenW = $clog2(MaxLabel + 1);
  localparam int PosW = $clog2(MaxLabel + 3);
  localparam int BudgetW = 12;
  localparam logic [BudgetW-1:0] BudgetReset = 12'd512;
  localparam logic [7:0] DotChar = 8'h2E;
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_FETCH,
    S_TAKE
  } dnle_state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic fetch;
    logic take;
  } dnle_cmd_t;

  typedef struct packed {
    logic no_bytes;
    logic byte_last;
    logic need_out;
    logic out_free;
  } dnle_status_t;

endpackage

>>> design/dnle_ctrl.sv
// controller state machine of the dns name label encoder
module dnle_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   name_valid,
  output logic                   name_stall,
  input  dnle_pkg::dnle_status_t status,
  output dnle_pkg::dnle_cmd_t    cmd
);
  import dnle_pkg::*;

  dnle_state_t state;
  dnle_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    name_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        name_stall = 1'b0;
        if (name_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = status.no_bytes ? S_IDLE : S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        // wait here while a full pair or the last byte has no room in the output register
        if (!status.need_out || status.out_free) begin
          cmd.take = 1'b1;
          state_next = status.byte_last ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/dnle_datapath.sv
// label buffer, budget tracking, byte packing and output register
module dnle_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dnle_pkg::BudgetW-1:0]  cfg_data,
  input  logic [7:0]                    name_byte,
  input  logic                          end_of_name,
  input  dnle_pkg::dnle_cmd_t           cmd,
  output dnle_pkg::dnle_status_t        status,
  input  logic                          wire_stall,
  output logic                          wire_valid,
  output logic [7:0]                    first_byte,
  output logic [7:0]                    second_byte,
  output logic [1:0]                    byte_count,
  output logic                          idn_label,
  output logic                          name_done,
  output logic                          last
);
  import dnle_pkg::*;

  logic [BudgetW-1:0] budget;
  logic [BudgetW-1:0] space_left;
  logic               aborted;
  logic [LenW-1:0]    label_count;
  logic               high_bit_seen;
  logic [7:0]         label_mem [MaxLabel];

  logic [LenW-1:0]    flush_len;
  logic               flush_flag;
  logic               flush_ok;
  logic               do_flush;
  logic               is_end;
  logic [PosW-1:0]    pos;
  logic [PosW-1:0]    total;
  logic [7:0]         rdata;
  logic [7:0]         hold_byte;
  logic               hold_tag;
  logic               hold_full;

  logic               is_dot;
  logic               flush_now;
  logic               ok;
  logic               cut;
  logic [LenW-1:0]    cut_len;
  logic [LenW-1:0]    len_now;
  logic               store_byte;
  logic [BudgetW-1:0] len_plus1;
  logic [PosW-1:0]    total_next;
  logic [LenW-1:0]    rd_addr;
  logic               in_label;
  logic [7:0]         byte_val;
  logic               byte_tag;
  logic               out_free;
  logic               load_out;

  // flush length: saturated count, cut so length byte plus label fit the budget
  always_comb begin
    is_dot     = (name_byte == DotChar);
    flush_now  = end_of_name || (!aborted && is_dot);
    ok         = !aborted && (space_left != '0);
    cut        = (space_left <= BudgetW'(label_count));
    cut_len    = LenW'(space_left - BudgetW'(1));
    len_now    = !ok ? '0 : (cut ? cut_len : label_count);
    store_byte = !end_of_name && !aborted && !is_dot
                 && (label_count < LenW'(MaxLabel));
    len_plus1  = BudgetW'(flush_len) + BudgetW'(1);
    total_next = (do_flush && (flush_len != '0)) ? PosW'(flush_len) + PosW'(1) : '0;
    total_next = total_next + PosW'(is_end);
    rd_addr    = LenW'(pos - PosW'(1));
  end

  // wire byte at pos: length byte, label bytes, then the closing zero byte
  always_comb begin
    in_label = (flush_len != '0) && (pos <= PosW'(flush_len));
    if (!in_label) begin
      byte_val = ZeroByte;
    end else if (pos == '0) begin
      byte_val = 8'(flush_len);
    end else begin
      byte_val = rdata;
    end
    byte_tag = in_label && flush_flag;
    out_free = !wire_valid || !wire_stall;
    load_out = cmd.take && (hold_full || status.byte_last);
  end

  always_comb begin
    status.no_bytes  = (total_next == '0);
    status.byte_last = (PosW'(pos + PosW'(1)) == total);
    status.need_out  = hold_full || status.byte_last;
    status.out_free  = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      budget        <= BudgetReset;
      space_left    <= BudgetReset;
      aborted       <= 1'b0;
      label_count   <= '0;
      high_bit_seen <= 1'b0;
      hold_full     <= 1'b0;
      wire_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        budget     <= cfg_data;
        space_left <= cfg_data;
        aborted    <= 1'b0;
      end
      if (cmd.accept) begin
        if (flush_now) begin
          label_count   <= '0;
          high_bit_seen <= 1'b0;
        end else if (!aborted) begin
          high_bit_seen <= high_bit_seen | name_byte[7];
          if (store_byte) begin
            label_count <= label_count + LenW'(1);
          end
        end
      end
      if (cmd.setup && do_flush) begin
        if (is_end) begin
          space_left <= budget;
          aborted    <= 1'b0;
        end else if (!flush_ok) begin
          aborted <= 1'b1;
        end else if (flush_len != '0) begin
          space_left <= space_left - len_plus1;
          aborted    <= (space_left == len_plus1);
        end
      end
      if (cmd.take) begin
        hold_full <= !load_out;
      end
      if (load_out) begin
        wire_valid <= 1'b1;
      end else if (wire_valid && !wire_stall) begin
        wire_valid <= 1'b0;
      end
    end
  end

  // payload registers and label memory
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      do_flush <= flush_now;
      is_end   <= end_of_name;
      if (flush_now) begin
        flush_len  <= len_now;
        flush_flag <= high_bit_seen;
        flush_ok   <= ok;
      end
      if (store_byte) begin
        label_mem[label_count] <= name_byte;
      end
    end
    if (cmd.setup) begin
      pos   <= '0;
      total <= total_next;
    end
    if (cmd.fetch && (rd_addr < LenW'(MaxLabel))) begin
      rdata <= label_mem[rd_addr];
    end
    if (cmd.take) begin
      pos <= pos + PosW'(1);
      if (!load_out) begin
        hold_byte <= byte_val;
        hold_tag  <= byte_tag;
      end
    end
    if (load_out) begin
      if (hold_full) begin
        first_byte  <= hold_byte;
        second_byte <= byte_val;
        byte_count  <= 2'd2;
        idn_label   <= hold_tag | byte_tag;
      end else begin
        first_byte  <= byte_val;
        second_byte <= ZeroByte;
        byte_count  <= 2'd1;
        idn_label   <= byte_tag;
      end
      name_done <= status.byte_last && is_end;
      last      <= status.byte_last;
    end
  end

endmodule

>>> design/dns_name_label_encoder.sv
// top level of the dns name label encoder: controller plus datapath
//
// channel   signals                                  direction  payload
// name      name_valid / name_stall                  in         name_byte, end_of_name
// wire      wire_valid / wire_stall                  out        first_byte, second_byte,
//                                                               byte_count, idn_label,
//                                                               name_done, last
// config    cfg_we                                   in         cfg_data (space budget)
//
// a plain name byte is accepted, then passes through the setup state
// a flush of n wire bytes passes accept and setup, then fetch and take for each
// byte, with one registered label memory read per byte; take waits on wire_stall
// the output register holds the last item while the next name item is accepted
// rst is synchronous; it loads a space budget of 512 and empties the label
// the label memory has no reset, only written entries reach the wire
module dns_name_label_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dnle_pkg::BudgetW-1:0]  cfg_data,
  input  logic                          name_valid,
  output logic                          name_stall,
  input  logic [7:0]                    name_byte,
  input  logic                          end_of_name,
  output logic                          wire_valid,
  input  logic                          wire_stall,
  output logic [7:0]                    first_byte,
  output logic [7:0]                    second_byte,
  output logic [1:0]                    byte_count,
  output logic                          idn_label,
  output logic                          name_done,
  output logic                          last
);
  import dnle_pkg::*;

  // commands from the controller, status back from the datapath
  dnle_cmd_t    cmd;
  dnle_status_t status;

  // sequencer: idle, setup, then fetch and take for each wire byte
  dnle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .name_valid (name_valid),
    .name_stall (name_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // label buffer, budget state, pair packing and output register
  dnle_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .name_byte   (name_byte),
    .end_of_name (end_of_name),
    .cmd         (cmd),
    .status      (status),
    .wire_stall  (wire_stall),
    .wire_valid  (wire_valid),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .byte_count  (byte_count),
    .idn_label   (idn_label),
    .name_done   (name_done),
    .last        (last)
  );

endmodule

>>> design/dnle_checker.sv
// port level checks of the dns name label encoder and their bind
module dnle_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          name_valid,
  input logic                          name_stall,
  input logic                          wire_valid,
  input logic                          wire_stall,
  input logic [7:0]                    first_byte,
  input logic [7:0]                    second_byte,
  input logic [1:0]                    byte_count,
  input logic                          idn_label,
  input logic                          name_done,
  input logic                          last
);

  // a held item keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    wire_valid && wire_stall |=> wire_valid && $stable(first_byte)
      && $stable(second_byte) && $stable(byte_count) && $stable(idn_label)
      && $stable(name_done) && $stable(last))
    else $error("wire item changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    wire_valid |-> (byte_count == 2'd1) || (byte_count == 2'd2))
    else $error("bad byte count");

  // the closing zero byte ends the output of the end marker
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    wire_valid && name_done |-> last
      && ((byte_count == 2'd2) ? (second_byte == 8'h00) : (first_byte == 8'h00)))
    else $error("closing item malformed");

  // every accepted item is worked on before the next one is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    name_valid && !name_stall |=> name_stall)
    else $error("item accepted back to back");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (.*);

>>> bench/dnle_checker.sv
// channel monitor, wire form predictor and result comparison for the dns name label encoder
`timescale 1ns / 1ps

module dnle_scoreboard
  import dnle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BudgetW-1:0] cfg_data,
  input  logic               name_valid,
  input  logic               name_stall,
  input  logic [7:0]         name_byte,
  input  logic               end_of_name,
  input  logic               wire_valid,
  input  logic               wire_stall,
  input  logic [7:0]         first_byte,
  input  logic [7:0]         second_byte,
  input  logic [1:0]         byte_count,
  input  logic               idn_label,
  input  logic               name_done,
  input  logic               last,
  output int                 mismatches,
  output int                 pending_words,
  output int                 live_items
);

  typedef struct packed {
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic [1:0] count;
    logic       idn;
    logic       done;
    logic       lst;
  } wire_word_t;

  wire_word_t         wire_words_q[$];
  logic [7:0]         label_mem [MaxLabel];
  int unsigned        lbl_fill;
  logic               hi_seen;
  logic               name_cut;
  logic [BudgetW-1:0] budget_reg;
  logic [BudgetW-1:0] room_left;
  logic [7:0]         wire_bytes[$];
  logic               wire_tags[$];
  int                 err_total;
  int                 live_total;

  function automatic void flush_label();
    int unsigned n;
    int unsigned i;
    n = lbl_fill;
    if (name_cut || room_left == 0) begin
      name_cut = 1'b1;
    end else begin
      if (n > MaxLabel) n = MaxLabel;
      // budget cut: length byte plus label must fit
      if (room_left < n + 1) n = room_left - 1;
      if (n != 0) begin
        wire_bytes.push_back(n[7:0]);
        wire_tags.push_back(hi_seen);
        for (i = 0; i < n; i++) begin
          wire_bytes.push_back(label_mem[i]);
          wire_tags.push_back(hi_seen);
        end
        room_left = room_left - BudgetW'(n + 1);
        if (room_left == 0) name_cut = 1'b1;
      end
    end
    lbl_fill = 0;
    hi_seen = 1'b0;
  endfunction

  function automatic void predict_wire(logic [7:0] b, logic eon);
    int         done_pos;
    int         words;
    int         k;
    int         p;
    logic       has_done;
    wire_word_t w;
    wire_bytes.delete();
    wire_tags.delete();
    has_done = 1'b0;
    done_pos = 0;
    if (eon) begin
      flush_label();
      done_pos = wire_bytes.size();
      has_done = 1'b1;
      wire_bytes.push_back(ZeroByte);
      wire_tags.push_back(1'b0);
      room_left = budget_reg;
      name_cut = 1'b0;
    end else if (name_cut) begin
      // rest of the name is dropped
    end else if (b == DotChar) begin
      flush_label();
    end else begin
      if (b[7]) hi_seen = 1'b1;
      if (lbl_fill < MaxLabel) begin
        label_mem[lbl_fill] = b;
        lbl_fill++;
      end
    end
    words = (wire_bytes.size() + 1) / 2;
    for (k = 0; k < words; k++) begin
      p = 2 * k;
      w.count = (p + 1 < wire_bytes.size()) ? 2'd2 : 2'd1;
      w.first_b = wire_bytes[p];
      w.second_b = (w.count == 2) ? wire_bytes[p + 1] : 8'h00;
      w.idn = wire_tags[p] | ((w.count == 2) ? wire_tags[p + 1] : 1'b0);
      w.done = has_done && (done_pos == p || (w.count == 2 && done_pos == p + 1));
      w.lst = (k + 1 == words);
      wire_words_q.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_total++;
    $display("%0t: wire item %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_wire_word();
    wire_word_t w;
    if (wire_words_q.size() == 0) begin
      report_mismatch("with nothing pending, first_byte", first_byte, 0);
    end else begin
      w = wire_words_q.pop_front();
      if (first_byte !== w.first_b) report_mismatch("first_byte", first_byte, w.first_b);
      if (second_byte !== w.second_b) report_mismatch("second_byte", second_byte, w.second_b);
      if (byte_count !== w.count) report_mismatch("byte_count", byte_count, w.count);
      if (idn_label !== w.idn) report_mismatch("idn_label", idn_label, w.idn);
      if (name_done !== w.done) report_mismatch("name_done", name_done, w.done);
      if (last !== w.lst) report_mismatch("last", last, w.lst);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wire_words_q.delete();
      lbl_fill = 0;
      hi_seen = 1'b0;
      name_cut = 1'b0;
      budget_reg = BudgetReset;
      room_left = BudgetReset;
    end else begin
      // a result at this edge comes from an earlier item, so compare first
      if (wire_valid && !wire_stall) check_wire_word();
      if (cfg_we) begin
        budget_reg = cfg_data;
        room_left = cfg_data;
        name_cut = 1'b0;
      end
      if (name_valid && !name_stall) begin
        if (end_of_name || !name_cut) live_total++;
        predict_wire(name_byte, end_of_name);
      end
    end
    mismatches <= err_total;
    pending_words <= wire_words_q.size();
    live_items <= live_total;
  end

endmodule

>>> bench/tb_top.sv
// top of the dns name label encoder bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import dnle_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [BudgetW-1:0] cfg_data = '0;
  logic               name_valid = 1'b0;
  logic               name_stall;
  logic [7:0]         name_byte = 8'h00;
  logic               end_of_name = 1'b0;
  logic               wire_valid;
  logic               wire_stall = 1'b0;
  logic [7:0]         first_byte;
  logic [7:0]         second_byte;
  logic [1:0]         byte_count;
  logic               idn_label;
  logic               name_done;
  logic               last;

  // receiver hold-off, raised for a long stretch by hold_output
  logic holding = 1'b0;
  // per-cycle idle odds in percent for each side
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   mismatches;
  int   pending_words;
  int   live_items;

  always #5 clk = ~clk;

  dns_name_label_encoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .name_valid  (name_valid),
    .name_stall  (name_stall),
    .name_byte   (name_byte),
    .end_of_name (end_of_name),
    .wire_valid  (wire_valid),
    .wire_stall  (wire_stall),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .byte_count  (byte_count),
    .idn_label   (idn_label),
    .name_done   (name_done),
    .last        (last)
  );

  dnle_scoreboard u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .name_valid    (name_valid),
    .name_stall    (name_stall),
    .name_byte     (name_byte),
    .end_of_name   (end_of_name),
    .wire_valid    (wire_valid),
    .wire_stall    (wire_stall),
    .first_byte    (first_byte),
    .second_byte   (second_byte),
    .byte_count    (byte_count),
    .idn_label     (idn_label),
    .name_done     (name_done),
    .last          (last),
    .mismatches    (mismatches),
    .pending_words (pending_words),
    .live_items    (live_items)
  );

  // receiver: random stall, forced high during a hold-off
  always @(posedge clk) begin
    wire_stall <= holding || ($urandom_range(0, 99) < stall_pct);
  end

  // offer one item and hold it until the block takes it; valid stays high on
  // return so a following item goes out back to back
  task automatic send_item(input logic [7:0] b, input logic eon);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      name_valid <= 1'b0;
      @(posedge clk);
    end
    name_valid <= 1'b1;
    name_byte <= b;
    end_of_name <= eon;
    @(posedge clk);
    while (name_stall) @(posedge clk);
  endtask

  task automatic send_word(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // stop offering, wait out every pending wire item, then let a plain byte
  // that produced nothing finish its setup cycle
  task automatic drain_and_settle();
    name_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (12) @(posedge clk);
  endtask

  // budget writes happen only with the block idle
  task automatic write_budget(input logic [BudgetW-1:0] value);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic hold_output(input int cycles);
    holding <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding <= 1'b0;
  endtask

  // mostly host-name letters, some digits and hyphens, some raw bytes
  // (dots among them) and some bytes with the top bit set
  function automatic logic [7:0] pick_name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 75) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 80) return 8'h2D;
    if (r < 93) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 127));
  endfunction

  // one dotted name with random labels; long_first makes the first label
  // run past the label limit with a top-bit byte among the dropped ones
  task automatic send_random_name(input bit long_first);
    int labels;
    int len;
    int l;
    int i;
    labels = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) send_item(DotChar, 1'b0);
    for (l = 0; l < labels; l++) begin
      if (long_first && l == 0) len = 70;
      else if ($urandom_range(0, 11) == 0) len = $urandom_range(60, 70);
      else len = $urandom_range(0, 8);
      for (i = 0; i < len; i++) begin
        if (long_first && l == 0 && i == 66) send_item(8'hC3, 1'b0);
        else send_item(pick_name_char(), 1'b0);
      end
      // separators between labels, sometimes a trailing dot as well
      if (l + 1 < labels || $urandom_range(0, 4) == 0) send_item(DotChar, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int  ph;
    int  goal;
    bit  first;
    bit  rewritten;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty name: only the closing zero; the byte field is ignored
    send_item(8'hFF, 1'b1);
    // leading dot, repeated dots, a plain label, a flagged label, trailing dot
    send_item(DotChar, 1'b0);
    send_item(DotChar, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(DotChar, 1'b0);
    send_item(DotChar, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(DotChar, 1'b0);
    send_item(8'h00, 1'b1);

    // budget of 4: label cut to three bytes, budget spent, rest ignored
    write_budget(12'd4);
    send_word("abcd");
    send_item(DotChar, 1'b0);
    send_word("e");
    send_item(8'h2A, 1'b1);

    // budget of 1: label cut down to nothing
    write_budget(12'd1);
    send_word("x");
    send_item(8'h00, 1'b1);

    // zero budget: name aborts at once
    write_budget(12'd0);
    send_word("y");
    send_item(8'h00, 1'b1);

    // budget rewritten while a label is in progress restarts the budget
    write_budget(12'd3);
    send_word("ab");
    write_budget(12'hFFF);
    send_word("c");
    send_item(8'h00, 1'b1);

    // random names in three idling phases
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_budget(12'($urandom_range(8, 60)));
          send_idle_pct = 20;
          stall_pct <= 53;
        end
        1: begin
          write_budget(12'hFFF);
          send_idle_pct = 53;
          stall_pct <= 20;
        end
        default: begin
          write_budget(12'($urandom_range(1, 300)));
          send_idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      goal = live_items + 50;
      first = 1'b1;
      rewritten = 1'b0;
      while (live_items < goal) begin
        // long receiver hold-off while names keep coming, fills the block
        if (ph == 0 && first) begin
          fork
            hold_output(300);
          join_none
        end
        send_random_name(ph == 1 && first);
        // sender pause until every wire item is out
        if (ph == 1 && first) drain_and_settle();
        if (ph == 2 && !rewritten && live_items > goal - 35) begin
          write_budget(12'($urandom_range(1, 4095)));
          rewritten = 1'b1;
        end
        first = 1'b0;
      end
    end

    drain_and_settle();
    if (mismatches == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
